// ----- hw/rtl/ira_pkg.sv -----
package ira_pkg;

  localparam int unsigned VALUE_BITS    = 64;
  localparam int unsigned VALUE_W_DFLT  = 64;
  localparam int unsigned RADIX_W       = 6;
  localparam int unsigned DIGIT_W       = 6;
  localparam int unsigned CHAR_W        = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'h00;
  localparam logic [DIGIT_W-1:0] DIGIT_NINE = 6'd9;
  localparam logic [CHAR_W-1:0] DIGIT_TEN  = 7'd10;

  typedef struct packed {
    logic clear;
    logic shift;
  } ira_cell_ctl_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d <= DIGIT_NINE) begin
      ch = CHAR_ZERO + CHAR_W'(d);
    end else begin
      ch = CHAR_A + CHAR_W'(d) - DIGIT_TEN;
    end
    return ch;
  endfunction

endpackage

// ----- hw/rtl/ira_in_if.sv -----
interface ira_in_if import ira_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  operation;

  modport source (output valid, output value, output operation, input ready);
  modport sink (input valid, input value, input operation, output ready);
endinterface

// ----- hw/rtl/ira_out_if.sv -----
interface ira_out_if import ira_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;
  logic              overflow;

  modport source (output valid, output character, output last, output overflow, input ready);
  modport sink (input valid, input character, input last, input overflow, output ready);
endinterface

// ----- hw/rtl/ira_cell.sv -----
module ira_cell import ira_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ira_cell_ctl_t       ctl_i,
  input  logic [RADIX_W-1:0]  radix_i,
  input  logic                en_i,
  input  logic                carry_i,
  input  logic [DIGIT_W-1:0]  digit_i,
  output logic                en_o,
  output logic                carry_o,
  output logic [DIGIT_W-1:0]  digit_o
);

  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic               carry_q, carry_d;
  logic               en_q;
  logic [DIGIT_W:0]   sum;
  logic [DIGIT_W:0]   diff;
  logic               wrap;

  // One doubling step of the digit: d' = 2d + carry, reduced modulo the radix.
  assign sum  = {digit_q, carry_i};
  assign diff = sum - {1'b0, radix_i};
  assign wrap = (sum >= {1'b0, radix_i});

  always_comb begin
    digit_d = digit_q;
    carry_d = carry_q;
    if (ctl_i.clear) begin
      digit_d = '0;
    end else if (ctl_i.shift) begin
      digit_d = digit_i;
    end else if (en_i) begin
      digit_d = wrap ? diff[DIGIT_W-1:0] : sum[DIGIT_W-1:0];
      carry_d = wrap;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
    carry_q <= carry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else begin
      en_q <= en_i && !ctl_i.clear;
    end
  end

  assign en_o    = en_q;
  assign carry_o = carry_q;
  assign digit_o = digit_q;

endmodule

// ----- hw/rtl/integer_to_radix_ascii.sv -----
// The value bits enter the digit cells one per cycle, most significant first, and each
// step ripples one cell per cycle until the digits are final.
// The row then shifts out toward the top cell, one cell per cycle while the output is not
// stalled, skipping leading zeros; a minus sign goes out first for a negative value.
// A new request is taken only once the last result is out and the block is idle.
// The most negative signed value gives its single overflow result the cycle after accept.
// Reset sets the radix to 10 and returns the control to idle.
module integer_to_radix_ascii import ira_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_W_DFLT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  ira_in_if.sink             in_i,
  ira_out_if.source          out_o,
  input  logic               cfg_we_i,
  input  logic [RADIX_W-1:0] cfg_wdata_i
);

  localparam int unsigned CNT_W = $clog2(2 * VALUE_WIDTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_OVF  = 3'd1;
  localparam logic [2:0] ST_CONV = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   seen_q, seen_d;
  logic                   neg_q, neg_d;
  logic [RADIX_W-1:0]     radix_q;
  logic [RADIX_W-1:0]     base_q, base_d;
  logic [VALUE_WIDTH-1:0] bits_q, bits_d;

  logic [VALUE_WIDTH-1:0] v;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   is_neg;
  logic                   is_min;
  logic                   accept;
  logic                   feed_en;
  logic                   last_pos;
  logic                   conv_done;
  logic                   emit_show;
  logic                   advance;
  logic [DIGIT_W-1:0]     top_digit;
  logic [RADIX_W-1:0]     eff_radix;
  ira_cell_ctl_t          cell_ctl;

  logic [VALUE_WIDTH-1:0] en_in, en_out, car_in, car_out;
  logic [DIGIT_W-1:0]     dig_in  [VALUE_WIDTH];
  logic [DIGIT_W-1:0]     dig_out [VALUE_WIDTH];

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (radix_q < RADIX_MIN) begin
      eff_radix = RADIX_MIN;
    end else if (radix_q > RADIX_MAX) begin
      eff_radix = RADIX_MAX;
    end else begin
      eff_radix = radix_q;
    end
  end

  assign v      = in_i.value[VALUE_WIDTH-1:0];
  assign is_neg = in_i.operation && v[VALUE_WIDTH-1];
  assign is_min = is_neg && (v[VALUE_WIDTH-2:0] == '0);
  assign mag    = is_neg ? (~v + VALUE_WIDTH'(1)) : v;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  assign feed_en   = (state_q == ST_CONV) && (cnt_q < CNT_W'(VALUE_WIDTH));
  assign conv_done = (cnt_q == CNT_W'(2 * VALUE_WIDTH - 2));
  assign last_pos  = (cnt_q == CNT_W'(VALUE_WIDTH - 1));
  assign top_digit = dig_out[VALUE_WIDTH-1];
  assign emit_show = (state_q == ST_EMIT) && ((top_digit != '0) || seen_q || last_pos);
  assign advance   = (state_q == ST_EMIT) && (!emit_show || out_o.ready);

  assign cell_ctl.clear = accept;
  assign cell_ctl.shift = advance;

  // Row of digit cells; cell 0 is the least significant digit.
  for (genvar i = 0; i < VALUE_WIDTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign en_in[i]  = feed_en;
      assign car_in[i] = bits_q[VALUE_WIDTH-1];
      assign dig_in[i] = '0;
    end else begin : g_next
      assign en_in[i]  = en_out[i-1];
      assign car_in[i] = car_out[i-1];
      assign dig_in[i] = dig_out[i-1];
    end

    ira_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (cell_ctl),
      .radix_i (base_q),
      .en_i    (en_in[i]),
      .carry_i (car_in[i]),
      .digit_i (dig_in[i]),
      .en_o    (en_out[i]),
      .carry_o (car_out[i]),
      .digit_o (dig_out[i])
    );
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    seen_d  = seen_q;
    neg_d   = neg_q;
    base_d  = base_q;
    bits_d  = bits_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d  = '0;
          seen_d = 1'b0;
          neg_d  = is_neg;
          base_d = eff_radix;
          bits_d = mag;
          state_d = is_min ? ST_OVF : ST_CONV;
        end
      end
      ST_OVF: begin
        if (out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      ST_CONV: begin
        if (feed_en) begin
          bits_d = {bits_q[VALUE_WIDTH-2:0], 1'b0};
        end
        if (conv_done) begin
          cnt_d   = '0;
          state_d = neg_q ? ST_SIGN : ST_EMIT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_SIGN: begin
        if (out_o.ready) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (advance) begin
          if (emit_show) begin
            seen_d = 1'b1;
          end
          if (last_pos) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      seen_q  <= 1'b0;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      seen_q  <= seen_d;
      neg_q   <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    bits_q <= bits_d;
  end

  always_comb begin
    out_o.valid     = 1'b0;
    out_o.character = digit_char(top_digit);
    out_o.last      = last_pos;
    out_o.overflow  = 1'b0;
    case (state_q)
      ST_OVF: begin
        out_o.valid     = 1'b1;
        out_o.character = CHAR_NUL;
        out_o.last      = 1'b1;
        out_o.overflow  = 1'b1;
      end
      ST_SIGN: begin
        out_o.valid     = 1'b1;
        out_o.character = CHAR_MINUS;
        out_o.last      = 1'b0;
      end
      ST_EMIT: begin
        out_o.valid = emit_show;
      end
      default: begin
        out_o.valid = 1'b0;
      end
    endcase
  end

  // The top cell never produces a carry: VALUE_WIDTH digits hold any magnitude.
  a_no_digit_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_out[VALUE_WIDTH-1] |-> !car_out[VALUE_WIDTH-1])
    else $error("carry out of the most significant digit cell");

  // Step tokens only travel the row while a conversion is running.
  a_token_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_in[VALUE_WIDTH-1] |-> (state_q == ST_CONV))
    else $error("digit step outside conversion");

  // After the last result of a request is taken, the block takes a new request.
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last) |=> in_i.ready)
    else $error("input not ready after final result");

  // A minus sign is only shown for a negative signed request.
  a_sign_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.character == CHAR_MINUS)) |-> (neg_q && !out_o.last))
    else $error("minus sign on a non-negative request");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import ira_pkg::*;

  localparam int unsigned VALUE_WIDTH = 64;
  localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_WIDTH);
  localparam logic [63:0] SIGN_BIT = 64'd1 << (VALUE_WIDTH - 1);
  localparam int unsigned DRAIN_CYCLES = 3 * VALUE_WIDTH + 56;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              overflow;
  } char_result_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [RADIX_W-1:0] cfg_wdata;

  ira_in_if  in_bus ();
  ira_out_if out_bus ();

  integer_to_radix_ascii #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  char_result_t       expected_chars[$];
  logic [RADIX_W-1:0] radix_setting;
  int                 mismatch_count;
  bit                 idle_enabled;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // Builds the characters that one number should be printed as.
  function automatic void format_number(input logic [63:0] raw, input logic is_signed,
                                        input logic [RADIX_W-1:0] radix_reg);
    logic [63:0] magnitude;
    logic [63:0] base;
    logic [5:0]  digits[64];
    int          count;
    logic        negative;
    logic [5:0]  d;
    magnitude = raw & VALUE_MASK;
    if (radix_reg < RADIX_MIN) begin
      base = 64'(RADIX_MIN);
    end else if (radix_reg > RADIX_MAX) begin
      base = 64'(RADIX_MAX);
    end else begin
      base = 64'(radix_reg);
    end
    negative = 1'b0;
    count = 0;
    if (is_signed && magnitude[VALUE_WIDTH-1]) begin
      if (magnitude == SIGN_BIT) begin
        expected_chars.push_back(char_result_t'{CHAR_NUL, 1'b1, 1'b1});
        return;
      end
      negative = 1'b1;
      magnitude = (~magnitude + 64'd1) & VALUE_MASK;
    end
    do begin
      digits[count] = 6'(magnitude % base);
      magnitude = magnitude / base;
      count++;
    end while (magnitude != 64'd0 && count < 64);
    if (negative) begin
      expected_chars.push_back(char_result_t'{CHAR_MINUS, 1'b0, 1'b0});
    end
    for (int i = count - 1; i >= 0; i--) begin
      d = digits[i];
      if (d <= 6'd9) begin
        expected_chars.push_back(char_result_t'{CHAR_ZERO + CHAR_W'(d), i == 0, 1'b0});
      end else begin
        expected_chars.push_back(char_result_t'{CHAR_A + CHAR_W'(d - 6'd10), i == 0, 1'b0});
      end
    end
  endfunction

  function automatic logic [63:0] rand_number();
    logic [63:0] small_val;
    logic [63:0] pick;
    small_val = 64'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0: begin
        pick = {$urandom, $urandom};
      end
      1: begin
        pick = small_val;
      end
      2: begin
        pick = 64'($urandom);
      end
      3: begin
        pick = -small_val;
      end
      4: begin
        pick = SIGN_BIT | small_val;
      end
      default: begin
        pick = (SIGN_BIT - 64'd1) - small_val;
      end
    endcase
    return pick;
  endfunction

  // Sends one request and records its characters once it is taken.
  task automatic send_number(input logic [63:0] raw, input logic is_signed);
    int gap;
    @(negedge clk);
    if (idle_enabled && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.value = raw;
    in_bus.operation = is_signed;
    do begin
      @(posedge clk);
    end while (!in_bus.ready);
    format_number(raw, is_signed, radix_setting);
  endtask

  // Holds off new requests until every pending character has come out.
  task automatic drain_output();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] radix_val);
    drain_output();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = radix_val;
    radix_setting = radix_val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic test_reset_radix();
    send_number(64'd0, 1'b0);
    send_number(64'd0, 1'b1);
    send_number(64'd1, 1'b0);
    send_number({64{1'b1}}, 1'b0);
    send_number({64{1'b1}}, 1'b1);
    send_number(SIGN_BIT, 1'b1);
    send_number(SIGN_BIT, 1'b0);
    send_number(SIGN_BIT - 64'd1, 1'b1);
    send_number(64'd9, 1'b0);
    send_number(64'd10, 1'b0);
  endtask

  task automatic test_radix_extremes();
    write_radix(RADIX_MIN);
    send_number({64{1'b1}}, 1'b0);
    send_number(SIGN_BIT | 64'd1, 1'b1);
    send_number(64'd5, 1'b0);
    write_radix(RADIX_MAX);
    send_number(64'd35, 1'b0);
    send_number(64'd36, 1'b0);
    send_number({64{1'b1}}, 1'b0);
    send_number(SIGN_BIT, 1'b1);
  endtask

  // Radix settings outside 2..36 are clamped to the nearest legal base.
  task automatic test_radix_clamp();
    write_radix(6'd0);
    send_number(64'd6, 1'b0);
    write_radix(6'd1);
    send_number(64'd3, 1'b0);
    write_radix(6'd37);
    send_number(64'd36, 1'b0);
    write_radix(6'd63);
    send_number(64'd35, 1'b1);
  endtask

  task automatic test_hex_patterns();
    write_radix(6'd16);
    send_number(64'hDEAD_BEEF_0123_4567, 1'b0);
    send_number(64'hDEAD_BEEF_0123_4567, 1'b1);
    send_number(64'hFEDC_BA98_7654_3210, 1'b1);
  endtask

  task automatic test_random_numbers();
    logic [RADIX_W-1:0] phase_radix;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: phase_radix = RADIX_RESET;
        1: phase_radix = RADIX_MIN;
        2: phase_radix = RADIX_MAX;
        3: phase_radix = 6'd16;
        4: phase_radix = RADIX_W'($urandom_range(0, 63));
        5: phase_radix = RADIX_W'($urandom_range(2, 36));
        6: phase_radix = 6'd8;
        default: phase_radix = 6'd7;
      endcase
      // The closing phases run with both sides at full speed.
      if (phase >= 6) begin
        idle_enabled = 1'b0;
      end
      write_radix(phase_radix);
      for (int n = 0; n < 26; n++) begin
        send_number(rand_number(), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    int gap;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_enabled && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 16);
        out_bus.ready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_bus.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    char_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character 0x%0h with no request pending", out_bus.character);
        mismatch_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_bus.character !== want.character) begin
          $error("character: expected 0x%0h, got 0x%0h", want.character, out_bus.character);
          mismatch_count++;
        end
        if (out_bus.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_bus.last);
          mismatch_count++;
        end
        if (out_bus.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, out_bus.overflow);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.value = '0;
    in_bus.operation = 1'b0;
    radix_setting = RADIX_RESET;
    mismatch_count = 0;
    idle_enabled = 1'b1;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_reset_radix();
    test_radix_extremes();
    test_radix_clamp();
    test_hex_patterns();
    test_random_numbers();

    drain_output();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0) begin
      $error("%0d characters never arrived", expected_chars.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- integer_to_radix_ascii.f -----
hw/rtl/ira_pkg.sv
hw/rtl/ira_in_if.sv
hw/rtl/ira_out_if.sv
hw/rtl/ira_cell.sv
hw/rtl/integer_to_radix_ascii.sv
verif/testbench.sv
